FILE: hw/rtl/gcss_pkg.sv
// Package for the gaze cone screen selector.
// Shared constants, sequencer state type and divider control struct; no dependencies.
package gcss_pkg;

  localparam int MaxScreens = 64;
  localparam int CntW = $clog2(MaxScreens + 1);
  localparam int DW = 33;
  localparam int SqW = 68;
  localparam int LenW = 34;
  localparam int DotW = 54;
  localparam int QuoW = 54;
  localparam logic [6:0] NoScreen = 7'h7f;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FWD,
    S_SUB,
    S_SQ,
    S_ROOT,
    S_DOT,
    S_DIV,
    S_CMP,
    S_OUT
  } seq_state_t;

  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;

endpackage

FILE: hw/rtl/gcss_div.sv
// Bit-serial signed divider: truncated quotient of a dot product by length.
// Depends on gcss_pkg.
module gcss_div
  import gcss_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic signed [DotW-1:0] num,
  input  logic [LenW-1:0]        den,
  output div_ctl_t               ctl,
  output logic signed [QuoW-1:0] quo
);

  logic [DotW-1:0]   nmag;
  logic [LenW:0]     rem;
  logic [LenW:0]     trial;
  logic [QuoW-1:0]   q;
  logic [5:0]        cnt;
  logic              neg;
  logic              busy;

  assign trial = {rem[LenW-1:0], nmag[DotW-1]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 6'(DotW - 1);
      nmag <= num[DotW-1] ? DotW'(-num) : DotW'(num);
      neg  <= num[DotW-1];
      rem  <= '0;
      q    <= '0;
    end else if (busy) begin
      // restoring step, one quotient bit a cycle
      if (!trial[LenW]) begin
        rem <= trial;
        q   <= {q[QuoW-2:0], 1'b1};
      end else begin
        rem <= {rem[LenW-1:0], nmag[DotW-1]};
        q   <= {q[QuoW-2:0], 1'b0};
      end
      nmag <= nmag << 1;
      if (cnt == '0) busy <= 1'b0;
      cnt <= cnt - 6'd1;
    end
  end

  assign ctl.start = start;
  assign ctl.busy  = busy;
  assign quo = neg ? QuoW'(-q) : QuoW'(q);

endmodule

FILE: hw/rtl/gcss_datapath.sv
// Per-screen arithmetic: forward vector, offset, squared length, integer
// root and dot product; all products go through one shared multiplier. Needs gcss_pkg.
module gcss_datapath
  import gcss_pkg::*;
(
  input  logic                   clk,
  input  seq_state_t             state,
  input  logic [2:0]             step,
  input  logic signed [31:0]     screen_x,
  input  logic signed [31:0]     screen_y,
  input  logic signed [31:0]     screen_z,
  input  logic signed [31:0]     head_x,
  input  logic signed [31:0]     head_y,
  input  logic signed [31:0]     head_z,
  input  logic signed [15:0]     quat_w,
  input  logic signed [15:0]     quat_x,
  input  logic signed [15:0]     quat_y,
  input  logic signed [15:0]     quat_z,
  input  logic [5:0]             root_bit,
  output logic [LenW-1:0]        len,
  output logic signed [DotW-1:0] dot
);

  logic signed [DW-1:0]   dx, dy, dz;
  logic signed [33:0]     acc;
  logic signed [18:0]     fx, fy, fz;
  logic [SqW-1:0]         sumsq;
  logic signed [DW:0]     ma;
  logic signed [DW:0]     mb;
  logic signed [2*DW+1:0] prod;
  logic [LenW-1:0]        cand;
  logic [SqW-1:0]         cand_sq;

  // one shared multiplier; operands chosen by state and step
  always_comb begin
    ma = '0;
    mb = '0;
    cand = len | (LenW'(1) << root_bit);
    case (state)
      S_FWD: begin
        case (step)
          3'd0: begin ma = (DW+1)'(quat_x); mb = (DW+1)'(quat_z); end
          3'd1: begin ma = (DW+1)'(quat_w); mb = (DW+1)'(quat_y); end
          3'd2: begin ma = (DW+1)'(quat_w); mb = (DW+1)'(quat_x); end
          3'd3: begin ma = (DW+1)'(quat_y); mb = (DW+1)'(quat_z); end
          3'd4: begin ma = (DW+1)'(quat_x); mb = (DW+1)'(quat_x); end
          default: begin ma = (DW+1)'(quat_y); mb = (DW+1)'(quat_y); end
        endcase
      end
      S_SQ: begin
        case (step)
          3'd0: begin ma = (DW+1)'(dx); mb = (DW+1)'(dx); end
          3'd1: begin ma = (DW+1)'(dy); mb = (DW+1)'(dy); end
          default: begin ma = (DW+1)'(dz); mb = (DW+1)'(dz); end
        endcase
      end
      S_ROOT: begin
        ma = (DW+1)'(cand);
        mb = (DW+1)'(cand);
      end
      S_DOT: begin
        case (step)
          3'd0: begin ma = (DW+1)'(dx); mb = (DW+1)'(fx); end
          3'd1: begin ma = (DW+1)'(dy); mb = (DW+1)'(fy); end
          default: begin ma = (DW+1)'(dz); mb = (DW+1)'(fz); end
        endcase
      end
      default: ;
    endcase
  end

  assign prod    = ma * mb;
  assign cand_sq = SqW'(prod);

  // acc gathers 2*(a +/- b) in Q28; reduction truncates toward zero
  function automatic logic signed [18:0] q28_to_q14(input logic signed [33:0] v);
    logic signed [33:0] t;
    t = v[33] ? v + 34'sd16383 : v;
    return 19'(t >>> 14);
  endfunction

  always_ff @(posedge clk) begin
    case (state)
      S_FWD: begin
        case (step)
          3'd0: acc <= 34'(prod);
          3'd1: begin
            acc <= '0;
            fx  <= q28_to_q14(-((acc + 34'(prod)) <<< 1));
          end
          3'd2: acc <= 34'(prod);
          3'd3: begin
            acc <= '0;
            fy  <= q28_to_q14((acc - 34'(prod)) <<< 1);
          end
          3'd4: acc <= 34'(prod);
          default: fz <= q28_to_q14(((acc + 34'(prod)) <<< 1) - (34'sd1 <<< 28));
        endcase
      end
      S_SUB: begin
        dx <= DW'(screen_x) - DW'(head_x);
        dy <= DW'(screen_y) - DW'(head_y);
        dz <= DW'(screen_z) - DW'(head_z);
        sumsq <= '0;
        len   <= '0;
        dot   <= '0;
      end
      S_SQ:   sumsq <= sumsq + cand_sq;
      S_ROOT: if (cand_sq <= sumsq) len <= cand;
      S_DOT:  dot <= dot + DotW'(prod);
      default: ;
    endcase
  end

endmodule

FILE: hw/rtl/gaze_cone_screen_select.sv
// Top level of the gaze cone screen selector: sequencer, best tracking, I/O.
// Uses gcss_pkg, gcss_datapath and gcss_div.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+--------------------------------
//  in        | in_valid / in_ready       | screen_*, head_*, quat_*, last
//  out       | out_valid / out_ready     | chosen_screen
//  cfg       | cfg_valid / cfg_ready     | cfg_data (cone cosine)
//
// Per screen, request to request: 6 forward products, 1 offset, 3 squares,
// 34 root steps, 3 dot terms, the divider (start, 54 steps, finish), then
// compare, output and the idle state that accepts the next screen.
// A screen at zero distance skips the divider; one past the limit goes straight to compare.
// Reset (rst, synchronous) clears the sequencer and the query state.
// in_ready is low while a screen is worked; a last screen waits in compare
// while the previous result is still held.
module gaze_cone_screen_select
  import gcss_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] screen_x,
  input  logic signed [31:0] screen_y,
  input  logic signed [31:0] screen_z,
  input  logic signed [31:0] head_x,
  input  logic signed [31:0] head_y,
  input  logic signed [31:0] head_z,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  input  logic               last_screen,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [6:0]  chosen_screen,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic signed [15:0] cfg_data
);

  seq_state_t state, state_next;
  logic [2:0]  step, step_next;
  logic [5:0]  root_bit, root_bit_next;
  logic        div_start;
  div_ctl_t    div_ctl;

  logic signed [15:0] cone_cos;
  logic signed [15:0] best_cosine;
  logic [6:0]         best_index;
  logic [CntW-1:0]    screen_count;
  logic               first;

  logic signed [31:0] sx, sy, sz, hx, hy, hz;
  logic signed [15:0] qw, qx, qy, qz;
  logic               last;

  logic [LenW-1:0]        len;
  logic signed [DotW-1:0] dot;
  logic signed [QuoW-1:0] quo;
  logic signed [15:0]     cosv;
  logic signed [15:0]     base;
  logic                   cmp_hold;
  logic                   cmp_go;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  // a finished query may not overwrite a result still waiting
  assign cmp_hold = last && out_valid && !out_ready;
  assign cmp_go   = (state == S_CMP) && !cmp_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      cone_cos <= '0;
    end else if (cfg_valid && cfg_ready) begin
      cone_cos <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sx <= screen_x; sy <= screen_y; sz <= screen_z;
      hx <= head_x;   hy <= head_y;   hz <= head_z;
      qw <= quat_w;   qx <= quat_x;   qy <= quat_y;   qz <= quat_z;
      last <= last_screen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      step     <= '0;
      root_bit <= '0;
    end else begin
      state    <= state_next;
      step     <= step_next;
      root_bit <= root_bit_next;
    end
  end

  always_comb begin
    state_next    = state;
    step_next     = step;
    root_bit_next = root_bit;
    div_start     = 1'b0;
    case (state)
      S_IDLE: if (in_valid && in_ready) begin
        // over the limit: no evaluation, only the last flag matters
        state_next = (screen_count < CntW'(MaxScreens)) ? S_FWD : S_CMP;
        step_next  = '0;
      end
      S_FWD: begin
        step_next = step + 3'd1;
        if (step == 3'd5) begin
          state_next = S_SUB;
          step_next  = '0;
        end
      end
      S_SUB: state_next = S_SQ;
      S_SQ: begin
        step_next = step + 3'd1;
        if (step == 3'd2) begin
          state_next    = S_ROOT;
          step_next     = '0;
          root_bit_next = 6'd33;
        end
      end
      S_ROOT: begin
        root_bit_next = root_bit - 6'd1;
        if (root_bit == '0) state_next = S_DOT;
      end
      S_DOT: begin
        step_next = step + 3'd1;
        if (step == 3'd2) begin
          step_next  = '0;
          state_next = (len == '0) ? S_CMP : S_DIV;
        end
      end
      // dot takes its last term on the edge into S_DIV, so the divider is started from S_DIV
      S_DIV: begin
        if (step == 3'd0) begin
          div_start = 1'b1;
          step_next = 3'd1;
        end else if (!div_ctl.start && !div_ctl.busy) begin
          state_next = S_CMP;
          step_next  = '0;
        end
      end
      S_CMP: if (!cmp_hold) state_next = S_OUT;
      S_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  gcss_datapath u_dp (
    .clk      (clk),
    .state    (state),
    .step     (step),
    .screen_x (sx),
    .screen_y (sy),
    .screen_z (sz),
    .head_x   (hx),
    .head_y   (hy),
    .head_z   (hz),
    .quat_w   (qw),
    .quat_x   (qx),
    .quat_y   (qy),
    .quat_z   (qz),
    .root_bit (root_bit),
    .len      (len),
    .dot      (dot)
  );

  gcss_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (dot),
    .den   (len),
    .ctl   (div_ctl),
    .quo   (quo)
  );

  assign first = (screen_count == '0);
  assign base  = first ? cone_cos : best_cosine;

  always_comb begin
    if (quo > QuoW'(32767))       cosv = 16'sd32767;
    else if (quo < -QuoW'(32768)) cosv = -16'sd32768;
    else                          cosv = 16'(quo);
  end

  // S_CMP settles the query state; evaluated screens came through S_DIV
  logic evaluated;
  always_ff @(posedge clk) begin
    if (rst) begin
      evaluated <= 1'b0;
    end else if (state == S_DIV) begin
      evaluated <= 1'b1;
    end else if (cmp_go) begin
      evaluated <= 1'b0;
    end
  end

  logic signed [15:0] nb_cos;
  logic [6:0]         nb_idx;
  always_comb begin
    nb_cos = base;
    nb_idx = first ? NoScreen : best_index;
    if (evaluated && (cosv > base)) begin
      nb_cos = cosv;
      nb_idx = 7'(screen_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_cosine  <= '0;
      best_index   <= NoScreen;
      screen_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cmp_go && last) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmp_go) begin
        if (last) begin
          chosen_screen <= nb_idx;
          screen_count  <= '0;
          best_index    <= NoScreen;
          best_cosine   <= cone_cos;
        end else begin
          best_cosine <= nb_cos;
          best_index  <= nb_idx;
          if (screen_count < CntW'(MaxScreens)) screen_count <= screen_count + CntW'(1);
        end
      end
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE)
    else $error("ready outside idle");
  a_out_after_cmp: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_CMP)
    else $error("result without compare step");
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    screen_count <= CntW'(MaxScreens))
    else $error("screen count over limit");

endmodule
